/* rtl/irep_pkg.sv */
`timescale 1ns / 1ps
// Shared constants, types and result structs for the IR edge pulse recorder.
// No dependencies; every other file of the block depends on this package.
package irep_pkg;

  // Time base and frame budget
  localparam int TIME_BITS    = 48;
  localparam int CHUNK_W      = 8;
  localparam int CHUNK_SHIFT  = 15;
  localparam int AMT_W        = CHUNK_W + CHUNK_SHIFT;
  localparam int RUN_BITS     = 24;
  localparam int DUR_W        = 32;
  localparam int GAP_W        = 16;
  localparam int SUM_W        = CHUNK_SHIFT + 1;

  localparam logic [CHUNK_W-1:0] FRAME_CHUNKS = 8'd252;
  localparam logic [SUM_W-1:0]   CHUNK_US     = 16'd32767;
  localparam logic [GAP_W-1:0]   IDLE_RESET   = 16'd6000;
  localparam logic [DUR_W-1:0]   GAP_SAT      = 32'h8000_0000;

  // Input item kinds
  localparam logic MODE_EDGE = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  // Result queue sizing
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic signed [DUR_W-1:0] duration;
    logic                    is_gap;
    logic                    last;
  } result_t;

  // Results of one item: one or two, pushed as a single entry
  typedef struct packed {
    logic    valid;
    logic    two;
    result_t first;
    result_t second;
  } push_t;

  typedef struct packed {
    logic [QCNT_W-1:0] used;
  } queue_status_t;

endpackage

/* rtl/irep_item_if.sv */
`timescale 1ns / 1ps
// Input channel of the recorder: edge events and idle check ticks.
// Depends on irep_pkg for the time width.
interface irep_item_if;
  logic                           valid;
  logic                           ready;
  logic                           mode;
  logic [irep_pkg::TIME_BITS-1:0] now_us;
  logic                           level;

  modport source (output valid, mode, now_us, level, input ready);
  modport sink   (input valid, mode, now_us, level, output ready);
endinterface

/* rtl/irep_result_if.sv */
`timescale 1ns / 1ps
// Output channel of the recorder: signed run durations and gap markers.
// Depends on irep_pkg for the duration width.
interface irep_result_if;
  logic                              valid;
  logic                              ready;
  logic signed [irep_pkg::DUR_W-1:0] duration;
  logic                              is_gap;
  logic                              last;

  modport source (output valid, duration, is_gap, last, input ready);
  modport sink   (input valid, duration, is_gap, last, output ready);
endinterface

/* rtl/irep_cfg_if.sv */
`timescale 1ns / 1ps
// Configuration write channel carrying the idle gap register.
// Depends on irep_pkg for the register width.
interface irep_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [irep_pkg::GAP_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

/* rtl/irep_core.sv */
`timescale 1ns / 1ps
// Recorder core: input register, frame state and single-pass update logic.
// Depends on irep_pkg, irep_item_if and irep_cfg_if.
module irep_core (
  input  logic                    clk,
  input  logic                    rst,
  irep_item_if.sink               item,
  irep_cfg_if.sink                cfg,
  input  irep_pkg::queue_status_t qstat,
  output irep_pkg::push_t         push
);
  import irep_pkg::*;

  // Input register
  logic                 s1_valid;
  logic                 s1_mode;
  logic [TIME_BITS-1:0] s1_now;
  logic                 s1_level;

  // Configuration and frame state
  logic [GAP_W-1:0]           idle_gap_us;
  logic [TIME_BITS-1:0]       prev_edge_time, prev_edge_time_next;
  logic                       have_prev_edge, have_prev_edge_next;
  logic                       rose_last, rose_last_next;
  logic [CHUNK_W-1:0]         chunks_used, chunks_used_next;
  logic signed [RUN_BITS-1:0] run_total, run_total_next;

  // Update datapath
  logic [TIME_BITS-1:0]       delta;
  logic                       idle;
  logic [CHUNK_W-1:0]         space;
  logic [AMT_W-1:0]           cap;
  logic                       big;
  logic [AMT_W-1:0]           amount;
  logic [CHUNK_W-1:0]         hi;
  logic [SUM_W-1:0]           part_sum;
  logic [CHUNK_W-1:0]         extra;
  logic [CHUNK_W-1:0]         used;
  logic                       neg;
  logic                       flip;
  logic signed [RUN_BITS-1:0] run_base;
  logic signed [RUN_BITS-1:0] amount_s;
  logic [DUR_W-1:0]           gap_val;
  result_t                    run_res;
  push_t                      push_next;

  // Accept an item only when the queue can hold its results and the one in flight
  assign item.ready = !rst && ((QCNT_W'(qstat.used) + QCNT_W'(s1_valid))
                               < QCNT_W'(QUEUE_DEPTH));
  assign cfg.ready  = !rst;

  // Capture the input item
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= item.valid && item.ready;
    end
    if (item.valid && item.ready) begin
      s1_mode  <= item.mode;
      s1_now   <= item.now_us;
      s1_level <= item.level;
    end
  end

  // Elapsed time and chunk charge
  always_comb begin
    delta    = s1_now - prev_edge_time;
    idle     = delta > TIME_BITS'(idle_gap_us);
    space    = (chunks_used < FRAME_CHUNKS) ? (FRAME_CHUNKS - chunks_used) : '0;
    cap      = {space, {CHUNK_SHIFT{1'b0}}} - AMT_W'(space);
    big      = (delta[TIME_BITS-1:AMT_W] != '0) || (delta[AMT_W-1:0] >= cap);
    // Below the cap the whole time is charged; round the chunk count up
    hi       = delta[AMT_W-1:CHUNK_SHIFT];
    part_sum = SUM_W'(hi) + SUM_W'(delta[CHUNK_SHIFT-1:0]);
    if (part_sum == '0) begin
      extra = 8'd0;
    end else if (part_sum <= CHUNK_US) begin
      extra = 8'd1;
    end else begin
      extra = 8'd2;
    end
    if (big) begin
      amount = cap;
      used   = space;
    end else begin
      amount = delta[AMT_W-1:0];
      used   = hi + extra;
    end
    neg      = !s1_level;
    flip     = (run_total != '0) && (run_total[RUN_BITS-1] != neg);
    run_base = flip ? '0 : run_total;
    amount_s = signed'(RUN_BITS'(amount));
    gap_val  = (delta >= TIME_BITS'(GAP_SAT)) ? GAP_SAT : (DUR_W'(0) - delta[DUR_W-1:0]);
    run_res.duration = DUR_W'(run_total);
    run_res.is_gap   = 1'b0;
    run_res.last     = 1'b0;
  end

  // Next state and results for the registered item
  always_comb begin
    prev_edge_time_next = prev_edge_time;
    have_prev_edge_next = have_prev_edge;
    rose_last_next      = rose_last;
    chunks_used_next    = chunks_used;
    run_total_next      = run_total;
    push_next           = '0;
    push_next.first     = run_res;
    push_next.second    = run_res;
    if (s1_valid) begin
      if (s1_mode == MODE_TICK) begin
        // Idle line on a tick closes the frame
        if (chunks_used != '0 && idle) begin
          push_next.valid      = 1'b1;
          push_next.first.last = 1'b1;
          run_total_next       = '0;
          chunks_used_next     = '0;
        end
      end else if (!have_prev_edge) begin
        prev_edge_time_next = s1_now;
        have_prev_edge_next = 1'b1;
      end else if (idle && chunks_used != '0 && rose_last) begin
        // Edge after an idle gap: emit the run and the gap marker
        push_next.valid           = 1'b1;
        push_next.two             = 1'b1;
        push_next.second.duration = signed'(gap_val);
        push_next.second.is_gap   = 1'b1;
        push_next.second.last     = 1'b1;
        run_total_next            = '0;
        chunks_used_next          = '0;
        prev_edge_time_next       = s1_now;
      end else begin
        rose_last_next      = s1_level;
        prev_edge_time_next = s1_now;
        if (used != '0) begin
          push_next.valid  = flip;
          run_total_next   = neg ? (run_base - amount_s) : (run_base + amount_s);
          chunks_used_next = chunks_used + used;
        end
      end
    end
  end

  assign push = push_next;

  // Hold configuration and frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      idle_gap_us    <= IDLE_RESET;
      prev_edge_time <= '0;
      have_prev_edge <= 1'b0;
      rose_last      <= 1'b0;
      chunks_used    <= '0;
      run_total      <= '0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        idle_gap_us <= cfg.data;
      end
      prev_edge_time <= prev_edge_time_next;
      have_prev_edge <= have_prev_edge_next;
      rose_last      <= rose_last_next;
      chunks_used    <= chunks_used_next;
      run_total      <= run_total_next;
    end
  end

  // The frame budget is never overdrawn
  a_budget: assert property (@(posedge clk) disable iff (rst)
    chunks_used <= FRAME_CHUNKS)
    else $error("chunk budget exceeded");

  // An empty frame has no open run
  a_empty_run: assert property (@(posedge clk) disable iff (rst)
    chunks_used == '0 |-> run_total == '0)
    else $error("open run without charged chunks");

  // Once the first edge is seen it stays seen
  a_have_edge: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $past(have_prev_edge) |-> have_prev_edge)
    else $error("edge history lost");

  // A result set is only produced by an accepted item
  a_push_src: assert property (@(posedge clk) disable iff (rst)
    push.valid |-> s1_valid && $past(item.valid && item.ready))
    else $error("results without an accepted item");

endmodule

/* rtl/irep_out_queue.sv */
`timescale 1ns / 1ps
// Result queue: holds result sets of one or two results and drains one per transfer.
// Depends on irep_pkg and irep_result_if.
module irep_out_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  irep_pkg::push_t         push,
  output irep_pkg::queue_status_t qstat,
  irep_result_if.source           result
);
  import irep_pkg::*;

  push_t             entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] used, used_next;
  logic              sub;
  push_t             head;
  result_t           head_res;
  logic              xfer;
  logic              pop;

  assign head     = entries[rd_ptr];
  assign head_res = sub ? head.second : head.first;
  assign xfer     = result.valid && result.ready;
  assign pop      = xfer && (sub == head.two);

  assign result.valid    = used != '0;
  assign result.duration = head_res.duration;
  assign result.is_gap   = head_res.is_gap;
  assign result.last     = head_res.last;
  assign qstat.used      = used;

  // Store a result set
  always_ff @(posedge clk) begin
    if (push.valid) begin
      entries[wr_ptr] <= push;
    end
  end

  // Track occupancy
  always_comb begin
    used_next = used;
    if (push.valid && !pop) begin
      used_next = used + QCNT_W'(1);
    end else if (!push.valid && pop) begin
      used_next = used - QCNT_W'(1);
    end
  end

  // Advance pointers and the position within the head set
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      used   <= '0;
      sub    <= 1'b0;
    end else begin
      used <= used_next;
      if (push.valid) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
        sub    <= 1'b0;
      end else if (xfer) begin
        sub <= 1'b1;
      end
    end
  end

  // Never write into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push.valid |-> used != QCNT_W'(QUEUE_DEPTH))
    else $error("result queue overflow");

  // Occupancy stays within the depth
  a_depth: assert property (@(posedge clk) disable iff (rst)
    used <= QCNT_W'(QUEUE_DEPTH))
    else $error("result queue occupancy out of range");

  // The second result is only selected in a two-result set
  a_second: assert property (@(posedge clk) disable iff (rst)
    result.valid && sub |-> head.two)
    else $error("second result of a single-result set");

  // A gap marker always ends its frame
  a_gap_last: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.is_gap |-> result.last)
    else $error("gap marker not marked last");

endmodule

/* rtl/ir_edge_pulse_recorder.sv */
`timescale 1ns / 1ps
// IR edge pulse recorder: takes one edge event or idle tick per clock cycle and
// returns signed run durations, with a gap marker and a last flag at frame end.
// An accepted item is registered and fully processed in the next cycle; its zero,
// one or two results then enter a four-entry result queue that drains one result
// per output transfer. Input and configuration ready are low during reset; after
// it, input ready drops only when that queue, counting the item in flight, is
// full, so throughput is one item per cycle while the output keeps up, and
// two-result items (frame close by an edge) need two output transfers.
// Results pass the input register and a queue entry before reaching the output.
// The idle gap register may be written whenever no item is in flight.
// Depends on irep_pkg, the channel interfaces, irep_core and irep_out_queue.
module ir_edge_pulse_recorder (
  input  logic          clk,
  input  logic          rst,
  irep_item_if.sink     item,
  irep_cfg_if.sink      cfg,
  irep_result_if.source result
);
  import irep_pkg::*;

  push_t         push;
  queue_status_t qstat;

  // Frame state and per-item update
  irep_core u_core (
    .clk   (clk),
    .rst   (rst),
    .item  (item),
    .cfg   (cfg),
    .qstat (qstat),
    .push  (push)
  );

  // Buffer results towards the output
  irep_out_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .qstat  (qstat),
    .result (result)
  );

endmodule
